// ===== src/caret_color_code_parser_defines.svh =====
// ----------------------------------------------------------------------------
// caret color code parser assertion macros
// shared assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef CARET_COLOR_CODE_PARSER_DEFINES_SVH
`define CARET_COLOR_CODE_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

// checked property, off during reset
`define CCP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property, also during reset
`define CCP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CCP_ASSERT(label, clk, rst, prop, msg)
`define CCP_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== src/ccp_pkg.sv =====
// ----------------------------------------------------------------------------
// ccp_pkg
// types, constants and palette shared by the caret color code parser
// ----------------------------------------------------------------------------
`default_nettype none

package ccp_pkg;

  localparam int CHAR_W  = 16;
  localparam int COLOR_W = 24;
  localparam int HELD_W  = 8;
  localparam int HELD_N  = 7;
  localparam int CNT_W   = 3;

  localparam logic [CHAR_W-1:0] CARET  = 16'h005E;
  localparam logic [CHAR_W-1:0] LOWER_X = 16'h0078;
  localparam logic [CHAR_W-1:0] UPPER_X = 16'h0058;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH_FAIL,
    ST_RETRY,
    ST_FLUSH_END
  } ccp_state_t;

  // controller to datapath
  typedef struct packed {
    logic             latch;
    logic             use_input;
    logic             consume;
    logic             final_flag;
    logic             emit_held;
    logic             emit_empty;
    logic             clear_held;
    logic             restart;
    logic [CNT_W-1:0] held_idx;
  } ccp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CNT_W-1:0] held_count;
    logic [CNT_W-1:0] next_count;
    logic             fail;
    logic             emits_char;
    logic             out_free;
    logic             last_q;
  } ccp_status_t;

  function automatic logic [COLOR_W-1:0] palette(input logic [3:0] d);
    logic [COLOR_W-1:0] c;
    unique case (d)
      4'd0:    c = 24'h000000;
      4'd1:    c = 24'hFF0000;
      4'd2:    c = 24'h00FF00;
      4'd3:    c = 24'h0000FF;
      4'd4:    c = 24'hFFFF00;
      4'd5:    c = 24'hFF00FF;
      4'd6:    c = 24'h00FFFF;
      4'd7:    c = 24'hFFFFFF;
      4'd8:    c = 24'hB3B3B3;
      4'd9:    c = 24'h666666;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/ccp_datapath.sv =====
// ----------------------------------------------------------------------------
// ccp_datapath
// color state, held escape characters, escape decode and output register
// ----------------------------------------------------------------------------
`default_nettype none

module ccp_datapath import ccp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [CHAR_W-1:0]  text_char,
  input  wire logic               end_of_text,
  input  wire logic               cfg_valid,
  input  wire logic [COLOR_W-1:0] default_color,
  input  wire ccp_cmd_t           cmd,
  output ccp_status_t             st,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [CHAR_W-1:0]       out_char,
  output logic [COLOR_W-1:0]      char_color,
  output logic                    run_start,
  output logic                    char_present,
  output logic                    final_item
);

  logic [COLOR_W-1:0] dflt_color;
  logic [COLOR_W-1:0] cur_color;
  logic [CNT_W-1:0]   held_count;
  logic [HELD_W-1:0]  held [HELD_N];
  logic [COLOR_W-1:0] hex_acc;
  logic               next_run;
  logic               in_text;
  logic [CHAR_W-1:0]  char_q;
  logic               last_q;

  logic [CHAR_W-1:0]  sel_char;
  logic               is_digit;
  logic               is_x;
  logic               hex_ok;
  logic [3:0]         hex_val;
  logic [COLOR_W-1:0] hex_shift;

  logic [COLOR_W-1:0] color_next;
  logic [CNT_W-1:0]   count_next;
  logic [COLOR_W-1:0] hex_next;
  logic               run_next;
  logic               held_wr;
  logic               fail;
  logic               emits;
  logic               out_load;

  assign sel_char  = cmd.use_input ? text_char : char_q;
  assign is_digit  = (sel_char >= 16'h0030) && (sel_char <= 16'h0039);
  assign is_x      = (sel_char == LOWER_X) || (sel_char == UPPER_X);
  assign hex_shift = {hex_acc[COLOR_W-5:0], hex_val};

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (is_digit) begin
      hex_val = sel_char[3:0];
    end else if ((sel_char >= 16'h0061 && sel_char <= 16'h0066) ||
                 (sel_char >= 16'h0041 && sel_char <= 16'h0046)) begin
      // letters a-f and A-F share the low three bits: 1..6
      hex_val = 4'd9 + {1'b0, sel_char[2:0]};
    end else begin
      hex_ok = 1'b0;
    end
  end

  // one step of the escape parser on the selected character
  always_comb begin
    color_next = cur_color;
    count_next = held_count;
    hex_next   = hex_acc;
    run_next   = next_run;
    held_wr    = 1'b0;
    fail       = 1'b0;
    emits      = 1'b0;
    priority if (held_count == 3'd0) begin
      if (sel_char == CARET) begin
        held_wr    = 1'b1;
        count_next = 3'd1;
      end else begin
        emits    = 1'b1;
        run_next = 1'b0;
      end
    end else if (held_count == 3'd1) begin
      if (is_digit) begin
        color_next = palette(sel_char[3:0]);
        count_next = 3'd0;
        run_next   = 1'b1;
      end else if (is_x) begin
        held_wr    = 1'b1;
        count_next = 3'd2;
        hex_next   = '0;
      end else begin
        fail = 1'b1;
      end
    end else begin
      if (!hex_ok) begin
        fail = 1'b1;
      end else if (held_count == 3'd7) begin
        color_next = hex_shift;
        count_next = 3'd0;
        hex_next   = '0;
        run_next   = 1'b1;
      end else begin
        held_wr    = 1'b1;
        count_next = held_count + 3'd1;
        hex_next   = hex_shift;
      end
    end
  end

  assign out_load = cmd.emit_held || cmd.emit_empty || (cmd.consume && emits);

  always_ff @(posedge clk) begin
    if (rst) begin
      dflt_color <= '0;
      cur_color  <= '0;
      held_count <= '0;
      hex_acc    <= '0;
      next_run   <= 1'b1;
      in_text    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.latch) begin
        in_text <= 1'b1;
      end
      if (cmd.consume) begin
        cur_color  <= color_next;
        held_count <= count_next;
        hex_acc    <= hex_next;
        next_run   <= run_next;
      end
      if (cmd.emit_held) begin
        next_run <= 1'b0;
      end
      if (cmd.clear_held) begin
        held_count <= '0;
        hex_acc    <= '0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      // end of text: back to the start condition
      if (cmd.restart) begin
        cur_color  <= dflt_color;
        held_count <= '0;
        hex_acc    <= '0;
        next_run   <= 1'b1;
        in_text    <= 1'b0;
      end
      if (cfg_valid) begin
        dflt_color <= default_color;
        if (!in_text) begin
          cur_color <= default_color;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      char_q <= text_char;
      last_q <= end_of_text;
    end
    if (cmd.consume && held_wr) begin
      held[held_count] <= sel_char[HELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      priority if (cmd.emit_empty) begin
        out_char     <= '0;
        char_color   <= '0;
        run_start    <= 1'b0;
        char_present <= 1'b0;
        final_item   <= 1'b1;
      end else if (cmd.emit_held) begin
        out_char     <= {{(CHAR_W-HELD_W){1'b0}}, held[cmd.held_idx]};
        char_color   <= cur_color;
        run_start    <= next_run;
        char_present <= 1'b1;
        final_item   <= cmd.final_flag;
      end else begin
        out_char     <= sel_char;
        char_color   <= cur_color;
        run_start    <= next_run;
        char_present <= 1'b1;
        final_item   <= cmd.final_flag;
      end
    end
  end

  assign st.held_count = held_count;
  assign st.next_count = count_next;
  assign st.fail       = fail;
  assign st.emits_char = emits;
  assign st.out_free   = !out_valid || !out_stall;
  assign st.last_q     = last_q;

endmodule

`default_nettype wire

// ===== src/ccp_controller.sv =====
// ----------------------------------------------------------------------------
// ccp_controller
// sequences one request: fast path, drain after a failed escape, end flush
// ----------------------------------------------------------------------------
`default_nettype none

`include "caret_color_code_parser_defines.svh"

module ccp_controller import ccp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        end_of_text,
  input  wire ccp_status_t st,
  output ccp_cmd_t         cmd
);

  ccp_state_t       state;
  ccp_state_t       state_next;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_next;
  logic             idx_last;

  assign idx_last = (idx + 3'd1) == st.held_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    cmd          = '0;
    cmd.held_idx = idx;
    in_stall     = 1'b1;
    unique case (state)
      ST_IDLE: begin
        cmd.use_input = 1'b1;
        in_stall      = !st.out_free;
        if (in_valid && st.out_free) begin
          cmd.latch = 1'b1;
          idx_next  = '0;
          if (st.fail) begin
            state_next = ST_FLUSH_FAIL;
          end else if (end_of_text) begin
            state_next = ST_RETRY;
          end else begin
            cmd.consume = 1'b1;
          end
        end
      end
      ST_FLUSH_FAIL: begin
        // held characters go out as text, more output always follows
        if (st.out_free) begin
          cmd.emit_held = 1'b1;
          if (idx_last) begin
            cmd.clear_held = 1'b1;
            state_next     = ST_RETRY;
          end else begin
            idx_next = idx + 3'd1;
          end
        end
      end
      ST_RETRY: begin
        if (st.out_free) begin
          cmd.consume    = 1'b1;
          cmd.final_flag = st.last_q;
          idx_next       = '0;
          if (!st.last_q) begin
            state_next = ST_IDLE;
          end else if (st.emits_char) begin
            cmd.restart = 1'b1;
            state_next  = ST_IDLE;
          end else if (st.next_count == 3'd0) begin
            cmd.emit_empty = 1'b1;
            cmd.restart    = 1'b1;
            state_next     = ST_IDLE;
          end else begin
            state_next = ST_FLUSH_END;
          end
        end
      end
      ST_FLUSH_END: begin
        if (st.out_free) begin
          cmd.emit_held  = 1'b1;
          cmd.final_flag = idx_last;
          if (idx_last) begin
            cmd.restart = 1'b1;
            state_next  = ST_IDLE;
          end else begin
            idx_next = idx + 3'd1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `CCP_ASSERT(a_fail_has_held, clk, rst, (state == ST_FLUSH_FAIL) |-> (st.held_count != 3'd0), "drain after failed escape with nothing held")
  `CCP_ASSERT(a_idx_in_range, clk, rst, ((state == ST_FLUSH_FAIL) || (state == ST_FLUSH_END)) |-> (idx < st.held_count), "flush index past held characters")
  `CCP_ASSERT(a_load_when_free, clk, rst, (cmd.emit_held || cmd.emit_empty || (cmd.consume && st.emits_char)) |-> st.out_free, "output register loaded while occupied")

endmodule

`default_nettype wire

// ===== src/caret_color_code_parser.sv =====
// ----------------------------------------------------------------------------
// caret_color_code_parser
// tags each plain character of a text with its caret-code color
// ----------------------------------------------------------------------------
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   text_char, end_of_text
// out      output     out_valid / out_stall out_char, char_color, run_start,
//                                           char_present, final_item
// cfg      input      cfg_valid / cfg_ready default_color
//
// a plain character or an escape character is consumed straight from ST_IDLE
// a failed escape sends each held character out from ST_FLUSH_FAIL, then retries the character in ST_RETRY
// end of text goes through ST_RETRY, then ST_FLUSH_END for each character still held
// every output request goes through one output register; out_stall holds it
// rst is synchronous; no clearing pass, held characters need no reset
// ----------------------------------------------------------------------------
`default_nettype none

module caret_color_code_parser import ccp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [CHAR_W-1:0]  text_char,
  input  wire logic               end_of_text,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [CHAR_W-1:0]       out_char,
  output logic [COLOR_W-1:0]      char_color,
  output logic                    run_start,
  output logic                    char_present,
  output logic                    final_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [COLOR_W-1:0] default_color
);

  ccp_cmd_t    cmd;
  ccp_status_t st;

  assign cfg_ready = 1'b1;

  ccp_controller u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .end_of_text (end_of_text),
    .st          (st),
    .cmd         (cmd)
  );

  ccp_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .text_char     (text_char),
    .end_of_text   (end_of_text),
    .cfg_valid     (cfg_valid),
    .default_color (default_color),
    .cmd           (cmd),
    .st            (st),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .char_color    (char_color),
    .run_start     (run_start),
    .char_present  (char_present),
    .final_item    (final_item)
  );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: caret color code parser testbench
// drives text through the input channel with random gaps, stalls the output at
// random and checks every result field against a predictor of the parser.
// a directed table covers palette and hex escapes, failed escapes and end of
// text; random phases of escape sequences follow under different default colors
// ----------------------------------------------------------------------------
module tb_top import ccp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int ITEMS_PER_PHASE = 84;
  localparam int N_PHASES        = 5;

  localparam logic [CHAR_W-1:0] DIGIT_0 = 16'h0030;
  localparam logic [CHAR_W-1:0] DIGIT_9 = 16'h0039;
  localparam logic [CHAR_W-1:0] LOWER_A = 16'h0061;
  localparam logic [CHAR_W-1:0] LOWER_F = 16'h0066;
  localparam logic [CHAR_W-1:0] UPPER_A = 16'h0041;
  localparam logic [CHAR_W-1:0] UPPER_F = 16'h0046;
  localparam logic [CHAR_W-1:0] LOWER_G = 16'h0067;
  localparam logic [CHAR_W-1:0] LOWER_Z = 16'h007A;

  localparam logic [COLOR_W-1:0] PALETTE_RGB [10] = '{
    24'h000000, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
    24'hFF00FF, 24'h00FFFF, 24'hFFFFFF, 24'hB3B3B3, 24'h666666
  };

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic [COLOR_W-1:0] color;
    logic               run;
    logic               present;
    logic               last;
  } glyph_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              eot;
  } text_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic               eot;
    logic               typed;
    logic [CHAR_W-1:0]  x_ch;
    logic [COLOR_W-1:0] x_color;
    logic               x_run;
    logic               x_present;
    logic               x_last;
  } dir_row_t;

  localparam int N_DIRECTED = 28;
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{16'h0041, 1'b0, 1'b1, 16'h0041, 24'hFFFFFF, 1'b1, 1'b1, 1'b0},
    '{16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 24'hFFFFFF, 1'b0, 1'b1, 1'b0},
    '{16'h0000, 1'b0, 1'b1, 16'h0000, 24'hFFFFFF, 1'b0, 1'b1, 1'b0},
    // palette escape, last palette entry
    '{CARET,    1'b0, 1'b0, 16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0},
    '{16'h0039, 1'b0, 1'b0, 16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0},
    '{16'h0042, 1'b0, 1'b1, 16'h0042, 24'h666666, 1'b1, 1'b1, 1'b0},
    // double caret, then a hex escape in mixed case
    '{CARET,    1'b0, 1'b0, 16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0},
    '{CARET,    1'b0, 1'b0, 16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0},
    '{LOWER_X,  1'b0, 1'b0, 16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0},
    '{16'h0031, 1'b0, 1'b0, 16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0},
    '{16'h0061, 1'b0, 1'b0, 16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0},
    '{16'h0046, 1'b0, 1'b0, 16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0},
    '{16'h0030, 1'b0, 1'b0, 16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0},
    '{16'h0063, 1'b0, 1'b0, 16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0},
    '{16'h0045, 1'b0, 1'b0, 16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0},
    '{16'h005A, 1'b0, 1'b1, 16'h005A, 24'h1AF0CE, 1'b1, 1'b1, 1'b0},
    // non-ascii digit after a caret is plain text
    '{CARET,    1'b0, 1'b0, 16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0},
    '{16'h0660, 1'b0, 1'b0, 16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0},
    // full held buffer broken by a caret on the last character
    '{CARET,    1'b0, 1'b0, 16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0},
    '{UPPER_X,  1'b0, 1'b0, 16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0},
    '{16'h0031, 1'b0, 1'b0, 16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0},
    '{16'h0032, 1'b0, 1'b0, 16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0},
    '{16'h0033, 1'b0, 1'b0, 16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0},
    '{16'h0034, 1'b0, 1'b0, 16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0},
    '{16'h0035, 1'b0, 1'b0, 16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0},
    '{CARET,    1'b1, 1'b0, 16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0},
    // text ending on a consumed escape gives the empty end marker
    '{CARET,    1'b0, 1'b0, 16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0},
    '{16'h0035, 1'b1, 1'b1, 16'h0000, 24'h000000, 1'b0, 1'b0, 1'b1}
  };

  logic                clk;
  logic                rst           = 1'b1;
  logic                in_valid      = 1'b0;
  logic                in_stall;
  logic [CHAR_W-1:0]   text_char     = '0;
  logic                end_of_text   = 1'b0;
  logic                out_valid;
  logic                out_stall     = 1'b0;
  logic [CHAR_W-1:0]   out_char;
  logic [COLOR_W-1:0]  char_color;
  logic                run_start;
  logic                char_present;
  logic                final_item;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic [COLOR_W-1:0]  default_color = '0;

  caret_color_code_parser dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .text_char     (text_char),
    .end_of_text   (end_of_text),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .char_color    (char_color),
    .run_start     (run_start),
    .char_present  (char_present),
    .final_item    (final_item),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .default_color (default_color)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // parser state as predicted
  logic [COLOR_W-1:0] def_rgb    = '0;
  logic [COLOR_W-1:0] cur_rgb    = '0;
  logic [7:0]         held_text [HELD_N];
  int                 held_n     = 0;
  logic [COLOR_W-1:0] hex_acc    = '0;
  logic               fresh_run  = 1'b1;
  logic               in_text    = 1'b0;

  glyph_t     step_glyphs[$];
  glyph_t     expected_glyphs[$];
  text_item_t token_items[$];

  logic no_idle        = 1'b0;
  int   mismatches     = 0;
  int   glyphs_checked = 0;
  int   items_sent     = 0;
  int   texts_done     = 0;
  int   cfg_writes     = 0;
  int   quiet_cycles   = 0;

  function automatic void emit_glyph(input logic [CHAR_W-1:0] c);
    step_glyphs.push_back('{c, cur_rgb, fresh_run, 1'b1, 1'b0});
    fresh_run = 1'b0;
  endfunction

  function automatic void release_held();
    for (int k = 0; k < held_n; k++)
      emit_glyph({8'h00, held_text[k]});
    held_n  = 0;
    hex_acc = '0;
  endfunction

  function automatic int hex_val(input logic [CHAR_W-1:0] c);
    if (c >= DIGIT_0 && c <= DIGIT_9) return int'(c - DIGIT_0);
    if (c >= LOWER_A && c <= LOWER_F) return int'(c - LOWER_A) + 10;
    if (c >= UPPER_A && c <= UPPER_F) return int'(c - UPPER_A) + 10;
    return -1;
  endfunction

  // returns 0 when the character breaks the escape being held
  function automatic logic try_consume(input logic [CHAR_W-1:0] c);
    int v;
    if (held_n == 0) begin
      if (c == CARET) begin
        held_text[0] = CARET[7:0];
        held_n       = 1;
      end else begin
        emit_glyph(c);
      end
      return 1'b1;
    end
    if (held_n == 1) begin
      if (c >= DIGIT_0 && c <= DIGIT_9) begin
        cur_rgb   = PALETTE_RGB[c[3:0]];
        held_n    = 0;
        fresh_run = 1'b1;
        return 1'b1;
      end
      if (c == LOWER_X || c == UPPER_X) begin
        held_text[1] = c[7:0];
        held_n       = 2;
        hex_acc      = '0;
        return 1'b1;
      end
      return 1'b0;
    end
    v = hex_val(c);
    if (v < 0 || held_n > HELD_N) return 1'b0;
    hex_acc = {hex_acc[COLOR_W-5:0], v[3:0]};
    if (held_n == HELD_N) begin
      cur_rgb   = hex_acc;
      held_n    = 0;
      hex_acc   = '0;
      fresh_run = 1'b1;
    end else begin
      held_text[held_n] = c[7:0];
      held_n++;
    end
    return 1'b1;
  endfunction

  function automatic void parse_char(input logic [CHAR_W-1:0] c, input logic eot);
    glyph_t tail;
    step_glyphs.delete();
    in_text = 1'b1;
    if (!try_consume(c)) begin
      release_held();
      void'(try_consume(c));
    end
    if (eot) begin
      release_held();
      if (step_glyphs.size() == 0) begin
        step_glyphs.push_back('{16'h0000, 24'h000000, 1'b0, 1'b0, 1'b1});
      end else begin
        tail      = step_glyphs[step_glyphs.size()-1];
        tail.last = 1'b1;
        step_glyphs[step_glyphs.size()-1] = tail;
      end
      cur_rgb   = def_rgb;
      held_n    = 0;
      hex_acc   = '0;
      fresh_run = 1'b1;
      in_text   = 1'b0;
    end
  endfunction

  function automatic logic [CHAR_W-1:0] hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) return DIGIT_0 + 16'(v);
    return ($urandom_range(1) ? LOWER_A : UPPER_A) + 16'(v - 10);
  endfunction

  function automatic logic [CHAR_W-1:0] x_char();
    return $urandom_range(1) ? LOWER_X : UPPER_X;
  endfunction

  function automatic logic [CHAR_W-1:0] plain_char();
    if ($urandom_range(7) == 0) return 16'($urandom);
    return 16'($urandom_range(16'h007E, 16'h0020));
  endfunction

  // a character that usually breaks an escape
  function automatic logic [CHAR_W-1:0] breaker_char();
    case ($urandom_range(3))
      0:       return CARET;
      1:       return 16'($urandom);
      2:       return 16'($urandom_range(LOWER_Z, LOWER_G));
      default: return {8'($urandom_range(255, 1)), DIGIT_0[7:0] + 8'($urandom_range(9))};
    endcase
  endfunction

  function automatic void build_token();
    int               kind;
    int               n;
    int               eot_at;
    logic [CHAR_W-1:0] t[$];
    kind = $urandom_range(99);
    if (kind < 30) begin
      n = $urandom_range(3, 1);
      repeat (n) t.push_back(plain_char());
    end else if (kind < 45) begin
      t.push_back(CARET);
      t.push_back(DIGIT_0 + 16'($urandom_range(9)));
    end else if (kind < 70) begin
      t.push_back(CARET);
      t.push_back(x_char());
      repeat (6) t.push_back(hex_char());
    end else if (kind < 85) begin
      t.push_back(CARET);
      t.push_back(x_char());
      repeat ($urandom_range(5)) t.push_back(hex_char());
      t.push_back(breaker_char());
    end else begin
      t.push_back(CARET);
      t.push_back(breaker_char());
    end
    n      = t.size();
    eot_at = -1;
    // now and then the text ends partway through an escape
    if ($urandom_range(9) == 0) begin
      n      = $urandom_range(t.size(), 1);
      eot_at = n - 1;
    end else if ($urandom_range(7) == 0) begin
      eot_at = n - 1;
    end
    token_items.delete();
    for (int k = 0; k < n; k++)
      token_items.push_back('{t[k], k == eot_at});
  endfunction

  task automatic send_char(input text_item_t item, input logic use_typed, input glyph_t typed);
    if (!no_idle) begin
      while ($urandom_range(99) < 35) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    text_char   <= item.ch;
    end_of_text <= item.eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_char(item.ch, item.eot);
    if (use_typed) begin
      expected_glyphs.push_back(typed);
    end else begin
      foreach (step_glyphs[k]) expected_glyphs.push_back(step_glyphs[k]);
    end
    items_sent++;
    if (item.eot) texts_done++;
  endtask

  task automatic write_default_color(input logic [COLOR_W-1:0] rgb);
    cfg_valid     <= 1'b1;
    default_color <= rgb;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    def_rgb = rgb;
    // mid-text writes only apply from the next text
    if (!in_text) cur_rgb = rgb;
    cfg_writes++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_glyphs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void check_glyph();
    glyph_t want;
    if (expected_glyphs.size() == 0) begin
      $display("%0t: unexpected result, expected none, got char %h color %h", $time,
               out_char, char_color);
      mismatches++;
      return;
    end
    want = expected_glyphs.pop_front();
    glyphs_checked++;
    if (out_char !== want.ch) begin
      $display("%0t: out_char expected %h got %h", $time, want.ch, out_char);
      mismatches++;
    end
    if (char_color !== want.color) begin
      $display("%0t: char_color expected %h got %h", $time, want.color, char_color);
      mismatches++;
    end
    if (run_start !== want.run) begin
      $display("%0t: run_start expected %b got %b", $time, want.run, run_start);
      mismatches++;
    end
    if (char_present !== want.present) begin
      $display("%0t: char_present expected %b got %b", $time, want.present, char_present);
      mismatches++;
    end
    if (final_item !== want.last) begin
      $display("%0t: final_item expected %b got %b", $time, want.last, final_item);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < 35);
    if (!rst && out_valid && !out_stall) check_glyph();
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request moved for %0d cycles, %0d results outstanding", $time,
               quiet_cycles, expected_glyphs.size());
      $display("caret_color_code_parser verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    glyph_t             typed_g;
    logic [COLOR_W-1:0] rgb;
    int                 sent;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    write_default_color(24'hFFFFFF);
    for (int r = 0; r < N_DIRECTED; r++) begin
      typed_g = '{DIRECTED[r].x_ch, DIRECTED[r].x_color, DIRECTED[r].x_run,
                  DIRECTED[r].x_present, DIRECTED[r].x_last};
      send_char('{DIRECTED[r].ch, DIRECTED[r].eot}, DIRECTED[r].typed, typed_g);
    end
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       rgb = 24'h000000;
        2:       rgb = 24'hFFFFFF;
        4:       rgb = 24'h800001;
        default: rgb = 24'($urandom);
      endcase
      write_default_color(rgb);
      // one phase runs both channels flat out
      no_idle = (p == 2);
      sent    = 0;
      while (sent < ITEMS_PER_PHASE) begin
        build_token();
        foreach (token_items[k]) send_char(token_items[k], 1'b0, '0);
        sent += token_items.size();
      end
      settle();
    end

    $display("sent %0d characters over %0d completed texts, %0d default color writes",
             items_sent, texts_done, cfg_writes);
    $display("checked %0d results, %0d mismatches", glyphs_checked, mismatches);
    if (mismatches == 0) begin
      $display("caret_color_code_parser verification clean");
    end else begin
      $display("caret_color_code_parser verification failed");
    end
    $finish;
  end

endmodule
